[sv/ps2mct_pkg.sv]
package ps2mct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int OUT_COORD_W    = 12;
  localparam int EXT_W          = 13;
  localparam int CFG_IDX_W      = 1;

  localparam logic [EXT_W-1:0] X_EXT_RST = EXT_W'(800);
  localparam logic [EXT_W-1:0] Y_EXT_RST = EXT_W'(600);
  localparam int               POS_RST   = 100;

  // byte 0 layout
  localparam int SYNC_BIT   = 3;
  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;
  localparam int BTN_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_EXTENT = 1'b0,
    CFG_Y_EXTENT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [EXT_W-1:0] x_extent;
    logic [EXT_W-1:0] y_extent;
  } cfg_t;

  typedef struct packed {
    logic       from_aux_port;
    logic [7:0] data_byte;
  } stage_t;

endpackage

[sv/ps2mct_in_if.sv]
interface ps2mct_in_if;
  logic       valid;
  logic       ready;
  logic       from_aux_port;
  logic [7:0] data_byte;

  modport source (output valid, output from_aux_port, output data_byte, input ready);
  modport sink   (input valid, input from_aux_port, input data_byte, output ready);
endinterface

[sv/ps2mct_out_if.sv]
interface ps2mct_out_if
  import ps2mct_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OUT_COORD_W-1:0] cursor_x;
  logic [OUT_COORD_W-1:0] cursor_y;
  logic                   left_pressed;
  logic                   right_pressed;
  logic                   middle_pressed;
  logic                   packet_done;

  modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                  output right_pressed, output middle_pressed, output packet_done,
                  input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                  input right_pressed, input middle_pressed, input packet_done,
                  output ready);
endinterface

[sv/ps2mct_cfg_regs.sv]
module ps2mct_cfg_regs
  import ps2mct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EXT_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_EXTENT: cfg_nxt.x_extent = cfg_wdata;
        CFG_Y_EXTENT: cfg_nxt.y_extent = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_extent <= X_EXT_RST;
      cfg_r.y_extent <= Y_EXT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/ps2mct_in_reg.sv]
module ps2mct_in_reg
  import ps2mct_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  ps2mct_in_if.sink in_ch,
  output logic   s1_valid,
  output stage_t s1_item,
  input  logic   s1_ready
);

  logic   vld_r;
  logic   vld_nxt;
  stage_t item_r;
  logic   take;

  assign in_ch.ready = !vld_r || s1_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.ready) vld_nxt = in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.from_aux_port <= in_ch.from_aux_port;
      item_r.data_byte     <= in_ch.data_byte;
    end
  end

  assign s1_valid = vld_r;
  assign s1_item  = item_r;

endmodule

[sv/ps2mct_track.sv]
module ps2mct_track
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   s1_valid,
  input  stage_t s1_item,
  output logic   s1_ready,
  ps2mct_out_if.source out_ch
);

  localparam int SW = COORD_BITS + 2;
  localparam int CW = (COORD_BITS + 1 > EXT_W) ? COORD_BITS + 1 : EXT_W;
  localparam logic [CW-1:0] LIM = CW'(1) << COORD_BITS;

  // saturated extent, COORD_BITS+1 bits wide
  function automatic logic [COORD_BITS:0] sat_extent(input logic [EXT_W-1:0] ext);
    logic [CW-1:0] e;
    e = CW'(ext);
    if (ext == '0) e = CW'(1);
    if (e > LIM) e = LIM;
    return (COORD_BITS + 1)'(e);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic [SW-1:0] v,
                                                  input logic [COORD_BITS:0] e);
    logic [COORD_BITS-1:0] res;
    if (v[SW-1]) res = '0;
    else if (v[COORD_BITS:0] >= e) res = COORD_BITS'(e - 1'b1);
    else res = v[COORD_BITS-1:0];
    return res;
  endfunction

  phase_t                phase_r, phase_nxt;
  logic [7:0]            hb0_r, hb1_r;
  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [BTN_W-1:0]      btn_r, btn_nxt;

  logic                  ov_r, ov_nxt;
  logic [OUT_COORD_W-1:0] ox_r, oy_r;
  logic [BTN_W-1:0]      obtn_r;
  logic                  odone_r;

  logic                  take, accept_byte, upd;
  logic [SW-1:0]         sum_x, sum_y;
  logic [OUT_COORD_W+COORD_BITS-1:0] wide_x, wide_y;

  assign s1_ready    = !ov_r || out_ch.ready;
  assign take        = s1_valid && s1_ready;
  // a first byte without the sync bit is dropped to regain packet alignment
  assign accept_byte = take && s1_item.from_aux_port &&
                       !(phase_r == PH_FIRST && !s1_item.data_byte[SYNC_BIT]);
  assign upd         = accept_byte && (phase_r == PH_THIRD);

  assign sum_x = {2'b00, pos_x_r} + {{(SW-8){hb1_r[7]}}, hb1_r};
  assign sum_y = {2'b00, pos_y_r} - {{(SW-8){s1_item.data_byte[7]}}, s1_item.data_byte};

  always_comb begin
    phase_nxt = phase_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    btn_nxt   = btn_r;
    if (accept_byte) begin
      unique case (phase_r)
        PH_FIRST:  phase_nxt = PH_SECOND;
        PH_SECOND: phase_nxt = PH_THIRD;
        PH_THIRD: begin
          phase_nxt = PH_FIRST;
          btn_nxt   = hb0_r[BTN_W-1:0];
          pos_x_nxt = clamp(sum_x, sat_extent(cfg.x_extent));
          pos_y_nxt = clamp(sum_y, sat_extent(cfg.y_extent));
        end
        default:   phase_nxt = PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      pos_x_r <= COORD_BITS'(POS_RST);
      pos_y_r <= COORD_BITS'(POS_RST);
      btn_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      btn_r   <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_byte && phase_r == PH_FIRST)  hb0_r <= s1_item.data_byte;
    if (accept_byte && phase_r == PH_SECOND) hb1_r <= s1_item.data_byte;
  end

  // result register
  always_comb begin
    ov_nxt = ov_r;
    if (s1_ready) ov_nxt = s1_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  assign wide_x = {{OUT_COORD_W{1'b0}}, pos_x_nxt};
  assign wide_y = {{OUT_COORD_W{1'b0}}, pos_y_nxt};

  always_ff @(posedge clk) begin
    if (take) begin
      ox_r    <= wide_x[OUT_COORD_W-1:0];
      oy_r    <= wide_y[OUT_COORD_W-1:0];
      obtn_r  <= btn_nxt;
      odone_r <= upd;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.cursor_x       = ox_r;
  assign out_ch.cursor_y       = oy_r;
  assign out_ch.left_pressed   = obtn_r[BTN_LEFT];
  assign out_ch.right_pressed  = obtn_r[BTN_RIGHT];
  assign out_ch.middle_pressed = obtn_r[BTN_MIDDLE];
  assign out_ch.packet_done    = odone_r;

  a_hold_no_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(pos_x_r) && $stable(pos_y_r) && $stable(btn_r))
    else $error("cursor state moved without a completed packet");

  a_done_shown: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> ov_r && odone_r)
    else $error("completed packet not flagged in result");

  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> phase_r == PH_FIRST)
    else $error("byte phase did not wrap after packet");

  a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && !upd |=> !odone_r)
    else $error("packet_done set on a byte that closed no packet");

endmodule

[sv/ps2_mouse_cursor_tracker.sv]
// PS/2 mouse cursor tracker. Takes one controller byte per transfer on in_ch;
// bytes not flagged from_aux_port are ignored, and a first byte with bit 3
// clear is dropped to regain sync. Every byte taken yields exactly one
// result on out_ch with the current cursor position and button state;
// packet_done marks the byte that closed a three-byte packet, at which point
// X moves by signed byte 1, Y by minus signed byte 2, both clamped to
// 0 .. extent-1 (extent 0 acts as 1). Throughput is one byte per clock
// unless out_ch stalls; bytes pass the input and result registers, and a
// stalled out_ch backs up into in_ch.ready the same cycle. Extents are
// written through cfg_we/cfg_index/cfg_wdata (0: x_extent, 1: y_extent) and
// take effect at the next completed packet. Reset cursor is (100, 100).
module ps2_mouse_cursor_tracker
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ps2mct_in_if.sink            in_ch,
  ps2mct_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EXT_W-1:0]     cfg_wdata
);

  cfg_t   cfg;
  logic   s1_valid;
  logic   s1_ready;
  stage_t s1_item;

  ps2mct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ps2mct_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_ready (s1_ready)
  );

  ps2mct_track #(
    .COORD_BITS (COORD_BITS)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule
